>>> hw/rtl/atb_pkg.sv
package atb_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int WGT_W       = 17;
    localparam int SUM_W       = 27;
    localparam int RES_W       = 28;
    localparam int FRAC_BITS   = 16;
    localparam int PROB_W      = 17;
    localparam int DIV_CNT_W   = 5;

    localparam logic [WGT_W-1:0]  WEIGHT_MAX = WGT_W'(65536);
    localparam logic [PROB_W-1:0] PROB_ONE   = PROB_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0]  THRESH_ONE = SUM_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_MUL,
        S_SCAN_WR,
        S_PAIR_CHK,
        S_PAIR_S,
        S_PAIR_L,
        S_PAIR_RL,
        S_PAIR_DIV,
        S_LEFT_CHK,
        S_LEFT_WR,
        S_RD_MEM,
        S_RD_DIV,
        S_RD_OUT
    } state_t;

endpackage

>>> hw/rtl/atb_ram.sv
module atb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/atb_divider.sv
module atb_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [atb_pkg::SUM_W-1:0]    dividend,
    input  logic [atb_pkg::SUM_W-1:0]    divisor,
    output logic [atb_pkg::PROB_W-1:0]   quotient,
    output logic                         done
);

    // restoring divide of (dividend << FRAC_BITS) / divisor, one quotient bit a cycle;
    // dividend never exceeds divisor, so the quotient fits PROB_W bits
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [atb_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [atb_pkg::SUM_W-1:0]       rem_reg, rem_next;
    logic [atb_pkg::SUM_W-1:0]       div_reg, div_next;
    logic [atb_pkg::PROB_W-1:0]      q_reg, q_next;
    logic                            bit_reg, bit_next;
    logic [atb_pkg::SUM_W:0]         trial;
    logic [atb_pkg::SUM_W:0]         diff;
    logic                            ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
        bit_reg <= bit_next;
    end

    // trial subtract
    assign trial = {rem_reg, bit_reg};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = atb_pkg::DIV_CNT_W'(atb_pkg::PROB_W);
            rem_next  = dividend >> 1;
            bit_next  = dividend[0];
            div_next  = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[atb_pkg::SUM_W-1:0] : trial[atb_pkg::SUM_W-1:0];
            q_next   = {q_reg[atb_pkg::PROB_W-2:0], ge};
            bit_next = 1'b0;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == atb_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

>>> hw/rtl/alias_table_builder_core.sv
// Alias table builder (Vose alias method), exact integer arithmetic.
// Input stream s_*: tuser = mode (0 load weight, 1 read entry), tlast = last
// weight of a distribution, tdata = weight and read index. A load stores one
// weight (saturated to 65536); the load marked last starts the table build.
// A read returns one result on m_*: alias index, keep probability, original
// probability (Q1.16) and a status code. Loads return nothing.
// cfg_we/cfg_wdata set normalize_input (reset 1); write only while idle.
// Loads are taken back to back. The build after the last load runs a scan, one
// small/large pairing per popped small (each waits on the serial divider), a
// self-alias step per small with no large left and one per leftover large
// entry; s_tready is low throughout. A valid read uses a memory read plus,
// unless the threshold is zero, the shared divider; a rejected read uses neither.
// One result register sits at the output: while the receiver stalls, new
// requests are taken until a finished read waits for that register to be free.
// Reset clears count, sum, stacks and flags; the memories are not cleared and
// every entry that is read has been written by a build first.
module alias_table_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [16:0] weight, [26:17] read_index, rest zero
    input  logic        s_tlast,   // last_weight
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [9:0] alias_index, [26:10] keep_prob,
                                   // [43:27] original_prob, [45:44] status
    input  logic        cfg_we,
    input  logic        cfg_wdata  // normalize_input
);

    localparam int IW = atb_pkg::IDX_W;
    localparam int CW = atb_pkg::CNT_W;
    localparam int SW = atb_pkg::SUM_W;
    localparam int RW = atb_pkg::RES_W;
    localparam int PW = atb_pkg::PROB_W;
    localparam int WW = atb_pkg::WGT_W;

    atb_pkg::state_t state_reg, state_next;

    logic          norm_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          ready_reg, ready_next;
    logic          ov_reg, ov_next;
    logic [SW-1:0] thresh_reg, thresh_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [SW-1:0] prod_reg, prod_next;
    logic [CW-1:0] stop_reg, stop_next;
    logic [CW-1:0] ltop_reg, ltop_next;
    logic [IW-1:0] s_reg, s_next;
    logic [IW-1:0] l_reg, l_next;
    logic [SW-1:0] rs_reg, rs_next;

    // staged result, then output register
    logic [IW-1:0]    st_alias_reg, st_alias_next;
    logic [PW-1:0]    st_keep_reg, st_keep_next;
    logic [PW-1:0]    st_orig_reg, st_orig_next;
    atb_pkg::status_t st_status_reg, st_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [IW-1:0]    out_alias_reg, out_alias_next;
    logic [PW-1:0]    out_keep_reg, out_keep_next;
    logic [PW-1:0]    out_orig_reg, out_orig_next;
    atb_pkg::status_t out_status_reg, out_status_next;

    // memory ports
    logic          w_we;    logic [IW-1:0] w_waddr, w_raddr; logic [WW-1:0] w_wdata, w_rdata;
    logic          r_we;    logic [IW-1:0] r_waddr, r_raddr; logic [RW-1:0] r_wdata, r_rdata;
    logic          sm_we;   logic [IW-1:0] sm_waddr, sm_raddr; logic [IW-1:0] sm_wdata, sm_rdata;
    logic          lg_we;   logic [IW-1:0] lg_waddr, lg_raddr; logic [IW-1:0] lg_wdata, lg_rdata;
    logic          a_we;    logic [IW-1:0] a_waddr, a_raddr; logic [IW-1:0] a_wdata, a_rdata;
    logic          k_we;    logic [IW-1:0] k_waddr, k_raddr; logic [PW-1:0] k_wdata, k_rdata;

    logic          div_start;
    logic [SW-1:0] div_x;
    logic [PW-1:0] div_q;
    logic          div_done;

    // request fields
    logic          in_acc;
    logic [WW-1:0] in_w, w_sat;
    logic [IW-1:0] in_idx;
    logic [CW-1:0] cnt_eff;
    logic [RW-1:0] rl_sum, rl_val;
    logic          out_load;

    assign in_acc = s_tvalid & s_tready;
    assign in_w   = s_tdata[16:0];
    assign in_idx = s_tdata[26:17];
    assign w_sat  = (in_w > atb_pkg::WEIGHT_MAX) ? atb_pkg::WEIGHT_MAX : in_w;
    assign cnt_eff = ready_reg ? '0 : cnt_reg;

    // residue update for the large entry
    assign rl_sum = r_rdata + RW'(rs_reg);
    assign rl_val = (rl_sum >= RW'(thresh_reg)) ? (rl_sum - RW'(thresh_reg)) : '0;

    atb_ram #(.WIDTH(WW), .DEPTH(atb_pkg::MAX_ENTRIES)) u_weight (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr),
        .rdata(w_rdata));
    atb_ram #(.WIDTH(RW), .DEPTH(atb_pkg::MAX_ENTRIES)) u_residue (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr),
        .rdata(r_rdata));
    atb_ram #(.WIDTH(IW), .DEPTH(atb_pkg::MAX_ENTRIES)) u_small (
        .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata), .raddr(sm_raddr),
        .rdata(sm_rdata));
    atb_ram #(.WIDTH(IW), .DEPTH(atb_pkg::MAX_ENTRIES)) u_large (
        .clk(clk), .we(lg_we), .waddr(lg_waddr), .wdata(lg_wdata), .raddr(lg_raddr),
        .rdata(lg_rdata));
    atb_ram #(.WIDTH(IW), .DEPTH(atb_pkg::MAX_ENTRIES)) u_alias (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr),
        .rdata(a_rdata));
    atb_ram #(.WIDTH(PW), .DEPTH(atb_pkg::MAX_ENTRIES)) u_keep (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr),
        .rdata(k_rdata));

    atb_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_x),
        .divisor(thresh_reg), .quotient(div_q), .done(div_done));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atb_pkg::S_IDLE;
            norm_reg      <= 1'b1;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            ready_reg     <= 1'b0;
            ov_reg        <= 1'b0;
            stop_reg      <= '0;
            ltop_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                norm_reg <= cfg_wdata;
            end
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            ready_reg     <= ready_next;
            ov_reg        <= ov_next;
            stop_reg      <= stop_next;
            ltop_reg      <= ltop_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        thresh_reg     <= thresh_next;
        prod_reg       <= prod_next;
        s_reg          <= s_next;
        l_reg          <= l_next;
        rs_reg         <= rs_next;
        st_alias_reg   <= st_alias_next;
        st_keep_reg    <= st_keep_next;
        st_orig_reg    <= st_orig_next;
        st_status_reg  <= st_status_next;
        out_alias_reg  <= out_alias_next;
        out_keep_reg   <= out_keep_next;
        out_orig_reg   <= out_orig_next;
        out_status_reg <= out_status_next;
    end

    assign out_load = (state_reg == atb_pkg::S_RD_OUT) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        ready_next      = ready_reg;
        ov_next         = ov_reg;
        thresh_next     = thresh_reg;
        scan_next       = scan_reg;
        prod_next       = prod_reg;
        stop_next       = stop_reg;
        ltop_next       = ltop_reg;
        s_next          = s_reg;
        l_next          = l_reg;
        rs_next         = rs_reg;
        st_alias_next   = st_alias_reg;
        st_keep_next    = st_keep_reg;
        st_orig_next    = st_orig_reg;
        st_status_next  = st_status_reg;
        out_alias_next  = out_alias_reg;
        out_keep_next   = out_keep_reg;
        out_orig_next   = out_orig_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        w_we  = 1'b0; w_waddr  = cnt_eff[IW-1:0]; w_wdata  = w_sat; w_raddr = in_idx;
        r_we  = 1'b0; r_waddr  = scan_reg[IW-1:0]; r_wdata = RW'(prod_reg);
        r_raddr = sm_rdata;
        sm_we = 1'b0; sm_waddr = stop_reg[IW-1:0]; sm_wdata = scan_reg[IW-1:0];
        sm_raddr = IW'(stop_reg - 1'b1);
        lg_we = 1'b0; lg_waddr = ltop_reg[IW-1:0]; lg_wdata = scan_reg[IW-1:0];
        lg_raddr = IW'(ltop_reg - 1'b1);
        a_we  = 1'b0; a_waddr  = s_reg; a_wdata = l_reg; a_raddr = in_idx;
        k_we  = 1'b0; k_waddr  = s_reg; k_wdata = div_q; k_raddr = in_idx;
        div_start = 1'b0;
        div_x     = r_rdata[SW-1:0];

        unique case (state_reg)
            atb_pkg::S_IDLE:
            begin
                if (in_acc && !s_tuser)
                begin
                    // load: a load after a finished build starts a new distribution
                    if (ready_reg)
                    begin
                        ready_next = 1'b0;
                        ov_next    = 1'b0;
                    end
                    if (cnt_eff < CW'(atb_pkg::MAX_ENTRIES))
                    begin
                        w_we     = 1'b1;
                        sum_next = (ready_reg ? '0 : sum_reg) + SW'(w_sat);
                        cnt_next = cnt_eff + 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_eff;
                        sum_next = ready_reg ? '0 : sum_reg;
                        ov_next  = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = atb_pkg::S_INIT;
                    end
                end
                else if (in_acc)
                begin
                    // read: classify, fetch entry when valid
                    st_alias_next = '0;
                    st_keep_next  = '0;
                    st_orig_next  = '0;
                    priority if (!ready_reg)
                    begin
                        st_status_next = atb_pkg::ST_INVALID;
                        state_next     = atb_pkg::S_RD_OUT;
                    end
                    else if (ov_reg)
                    begin
                        st_status_next = atb_pkg::ST_OVERFLOW;
                        state_next     = atb_pkg::S_RD_OUT;
                    end
                    else if (CW'(in_idx) >= cnt_reg)
                    begin
                        st_status_next = atb_pkg::ST_INVALID;
                        state_next     = atb_pkg::S_RD_OUT;
                    end
                    else
                    begin
                        st_status_next = atb_pkg::ST_OK;
                        state_next     = atb_pkg::S_RD_MEM;
                    end
                end
            end

            atb_pkg::S_INIT:
            begin
                thresh_next = norm_reg ? sum_reg : atb_pkg::THRESH_ONE;
                stop_next   = '0;
                ltop_next   = '0;
                scan_next   = '0;
                state_next  = atb_pkg::S_SCAN_RD;
            end

            // scan: residue = weight * n, split into small / large
            atb_pkg::S_SCAN_RD:
            begin
                w_raddr = scan_reg[IW-1:0];
                if (scan_reg == cnt_reg)
                begin
                    state_next = atb_pkg::S_PAIR_CHK;
                end
                else
                begin
                    state_next = atb_pkg::S_SCAN_MUL;
                end
            end

            atb_pkg::S_SCAN_MUL:
            begin
                prod_next  = SW'(w_rdata) * SW'(cnt_reg);
                state_next = atb_pkg::S_SCAN_WR;
            end

            atb_pkg::S_SCAN_WR:
            begin
                r_we = 1'b1;
                if (prod_reg < thresh_reg)
                begin
                    sm_we     = 1'b1;
                    stop_next = stop_reg + 1'b1;
                end
                else
                begin
                    lg_we     = 1'b1;
                    ltop_next = ltop_reg + 1'b1;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = atb_pkg::S_SCAN_RD;
            end

            // pairing: pop a small, top it up from the top large
            atb_pkg::S_PAIR_CHK:
            begin
                if (stop_reg == '0)
                begin
                    state_next = atb_pkg::S_LEFT_CHK;
                end
                else
                begin
                    stop_next  = stop_reg - 1'b1;
                    state_next = atb_pkg::S_PAIR_S;
                end
            end

            atb_pkg::S_PAIR_S:
            begin
                s_next = sm_rdata;
                if (ltop_reg == '0)
                begin
                    a_we       = 1'b1;
                    a_waddr    = sm_rdata;
                    a_wdata    = sm_rdata;
                    k_we       = 1'b1;
                    k_waddr    = sm_rdata;
                    k_wdata    = atb_pkg::PROB_ONE;
                    state_next = atb_pkg::S_PAIR_CHK;
                end
                else
                begin
                    r_raddr    = sm_rdata;
                    state_next = atb_pkg::S_PAIR_L;
                end
            end

            atb_pkg::S_PAIR_L:
            begin
                rs_next    = r_rdata[SW-1:0];
                l_next     = lg_rdata;
                r_raddr    = lg_rdata;
                div_start  = 1'b1;
                state_next = atb_pkg::S_PAIR_RL;
            end

            atb_pkg::S_PAIR_RL:
            begin
                r_we    = 1'b1;
                r_waddr = l_reg;
                r_wdata = rl_val;
                a_we    = 1'b1;
                if (rl_val < RW'(thresh_reg))
                begin
                    ltop_next = ltop_reg - 1'b1;
                    sm_we     = 1'b1;
                    sm_wdata  = l_reg;
                    stop_next = stop_reg + 1'b1;
                end
                state_next = atb_pkg::S_PAIR_DIV;
            end

            atb_pkg::S_PAIR_DIV:
            begin
                if (div_done)
                begin
                    k_we       = 1'b1;
                    state_next = atb_pkg::S_PAIR_CHK;
                end
            end

            // leftovers alias themselves
            atb_pkg::S_LEFT_CHK:
            begin
                if (ltop_reg == '0)
                begin
                    ready_next = 1'b1;
                    state_next = atb_pkg::S_IDLE;
                end
                else
                begin
                    ltop_next  = ltop_reg - 1'b1;
                    state_next = atb_pkg::S_LEFT_WR;
                end
            end

            atb_pkg::S_LEFT_WR:
            begin
                a_we       = 1'b1;
                a_waddr    = lg_rdata;
                a_wdata    = lg_rdata;
                k_we       = 1'b1;
                k_waddr    = lg_rdata;
                k_wdata    = atb_pkg::PROB_ONE;
                state_next = atb_pkg::S_LEFT_CHK;
            end

            // read path
            atb_pkg::S_RD_MEM:
            begin
                st_alias_next = a_rdata;
                st_keep_next  = k_rdata;
                if (thresh_reg == '0)
                begin
                    st_orig_next = '0;
                    state_next   = atb_pkg::S_RD_OUT;
                end
                else
                begin
                    div_x      = SW'(w_rdata);
                    div_start  = 1'b1;
                    state_next = atb_pkg::S_RD_DIV;
                end
            end

            atb_pkg::S_RD_DIV:
            begin
                if (div_done)
                begin
                    st_orig_next = div_q;
                    state_next   = atb_pkg::S_RD_OUT;
                end
            end

            atb_pkg::S_RD_OUT:
            begin
                if (out_load)
                begin
                    out_alias_next  = st_alias_reg;
                    out_keep_next   = st_keep_reg;
                    out_orig_next   = st_orig_reg;
                    out_status_next = st_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = atb_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = atb_pkg::S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == atb_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_orig_reg, out_keep_reg, out_alias_reg};

    // stacks never hold more entries than were loaded
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (12'(stop_reg) + 12'(ltop_reg)) <= 12'(cnt_reg))
        else $error("stack depth exceeds entry count");

    // keep probability written never exceeds 1.0
    a_keep_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_we |-> (k_wdata <= atb_pkg::PROB_ONE))
        else $error("keep probability above one");

    // an ok result only comes from a built table
    a_ok_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (st_status_reg == atb_pkg::ST_OK)) |-> ready_reg)
        else $error("ok result without built table");

    // divider is only started from the sequencer's divide-issuing states
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> ((state_reg == atb_pkg::S_PAIR_RL) || (state_reg == atb_pkg::S_RD_DIV)))
        else $error("divider start out of sequence");

endmodule
